// ----- sv/xor_checked_frame_receiver_top_assert.svh -----
// Assertion macros for the framed byte receiver.
`ifndef XOR_CHECKED_FRAME_RECEIVER_TOP_ASSERT_SVH
`define XOR_CHECKED_FRAME_RECEIVER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define XCFR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define XCFR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/xcfr_pkg.sv -----
// Shared types and constants for the framed byte receiver.
package xcfr_pkg;

	localparam int MAX_PAYLOAD_DEF = 64;
	localparam int BYTE_W          = 8;
	localparam int CNT_W           = 7;
	localparam int STATUS_W        = 2;

	localparam logic [BYTE_W-1:0] SYNC_A      = 8'h06;
	localparam logic [BYTE_W-1:0] SYNC_B      = 8'h85;
	localparam logic [CNT_W-1:0]  CFG_LEN_RST = 7'd1;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_SYNC2,
		PH_LEN,
		PH_DATA,
		PH_CHECK,
		PH_EMIT
	} phase_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DATA    = 2'd0,
		ST_BAD_SUM = 2'd1,
		ST_BAD_LEN = 2'd2
	} status_t;

endpackage

// ----- sv/xor_checked_frame_receiver_top.sv -----
// Top level of the sync, length and XOR checked frame receiver.
// A status word is registered and leaves in the cycle after the byte causing it;
// a good checksum starts a store read, then each payload word is registered out, one
// word per cycle while out_ready holds. Input is shut in a payload run; else one
// byte per cycle, but length and checksum bytes wait while the output is full.
// Reset: arst_n clears phase, counters, length register (to 1) and the output valid.
`include "xor_checked_frame_receiver_top_assert.svh"

module xor_checked_frame_receiver_top #(
	parameter int MAX_PAYLOAD = xcfr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [xcfr_pkg::CNT_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [xcfr_pkg::BYTE_W-1:0]   rx_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [xcfr_pkg::BYTE_W-1:0]   data_byte,
	output logic [xcfr_pkg::STATUS_W-1:0] status,
	output logic                          last
);
	import xcfr_pkg::*;

	localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam logic [CNT_W-1:0] LEN_MAX = CNT_W'(MAX_PAYLOAD);

	phase_t              phase_q, phase_d;
	logic [CNT_W-1:0]    cfg_len_q;
	logic [CNT_W-1:0]    byte_count_q, byte_count_d;
	logic [BYTE_W-1:0]   running_xor_q, running_xor_d;
	logic [ADDR_W-1:0]   emit_idx_q, emit_idx_d;

	logic                out_valid_q;
	logic [BYTE_W-1:0]   data_byte_q, data_byte_d;
	logic [STATUS_W-1:0] status_q, status_d;
	logic                last_q, last_d;
	logic                load_out;

	logic                wr_en, rd_en;
	logic [ADDR_W-1:0]   rd_addr;
	logic [BYTE_W-1:0]   rd_data;

	logic                out_free, in_fire, step;
	logic                len_ok, xor_match, emit_last;
	logic [CNT_W-1:0]    count_inc;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (phase_q != PH_EMIT)
		&& (out_free || !((phase_q == PH_LEN) || (phase_q == PH_CHECK)));
	assign in_fire   = in_valid && in_ready;
	assign step      = in_fire && !cfg_we;
	assign count_inc = byte_count_q + CNT_W'(1);
	assign len_ok    = (rx_byte == BYTE_W'(cfg_len_q)) && (cfg_len_q != '0)
		&& (cfg_len_q <= LEN_MAX);
	assign xor_match = (rx_byte == running_xor_q);
	assign emit_last = (CNT_W'(emit_idx_q) == (cfg_len_q - CNT_W'(1)));

	xcfr_ram #(
		.DEPTH  (MAX_PAYLOAD),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (byte_count_q[ADDR_W-1:0]),
		.wr_data (rx_byte),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_comb begin
		phase_d = phase_q;
		if (cfg_we) begin
			phase_d = PH_HUNT;
		end else begin
			unique case (phase_q)
				PH_HUNT: begin
					if (step && (rx_byte == SYNC_A)) phase_d = PH_SYNC2;
				end
				PH_SYNC2: begin
					if (step) phase_d = (rx_byte == SYNC_B) ? PH_LEN : PH_HUNT;
				end
				PH_LEN: begin
					if (step) phase_d = len_ok ? PH_DATA : PH_HUNT;
				end
				PH_DATA: begin
					if (step && (count_inc >= cfg_len_q)) phase_d = PH_CHECK;
				end
				PH_CHECK: begin
					if (step) phase_d = xor_match ? PH_EMIT : PH_HUNT;
				end
				PH_EMIT: begin
					if (out_free && emit_last) phase_d = PH_HUNT;
				end
				default: phase_d = PH_HUNT;
			endcase
		end
	end

	always_comb begin
		byte_count_d  = byte_count_q;
		running_xor_d = running_xor_q;
		emit_idx_d    = emit_idx_q;
		wr_en         = 1'b0;
		rd_en         = 1'b0;
		rd_addr       = '0;
		load_out      = 1'b0;
		data_byte_d   = '0;
		status_d      = ST_DATA;
		last_d        = 1'b1;
		if (cfg_we) begin
			byte_count_d  = '0;
			running_xor_d = '0;
		end else begin
			unique case (phase_q)
				PH_HUNT: ;
				PH_SYNC2: begin
					if (step && (rx_byte != SYNC_B)) begin
						byte_count_d  = '0;
						running_xor_d = '0;
					end
				end
				PH_LEN: begin
					if (step) begin
						byte_count_d  = '0;
						running_xor_d = len_ok ? rx_byte : '0;
						if (!len_ok) begin
							load_out = 1'b1;
							status_d = ST_BAD_LEN;
						end
					end
				end
				PH_DATA: begin
					if (step) begin
						wr_en         = 1'b1;
						byte_count_d  = count_inc;
						running_xor_d = running_xor_q ^ rx_byte;
					end
				end
				PH_CHECK: begin
					if (step) begin
						byte_count_d  = '0;
						running_xor_d = '0;
						emit_idx_d    = '0;
						if (xor_match) begin
							rd_en = 1'b1;
						end else begin
							load_out = 1'b1;
							status_d = ST_BAD_SUM;
						end
					end
				end
				PH_EMIT: begin
					if (out_free) begin
						load_out    = 1'b1;
						data_byte_d = rd_data;
						last_d      = emit_last;
						if (!emit_last) begin
							rd_en      = 1'b1;
							rd_addr    = emit_idx_q + ADDR_W'(1);
							emit_idx_d = emit_idx_q + ADDR_W'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HUNT;
			cfg_len_q     <= CFG_LEN_RST;
			byte_count_q  <= '0;
			running_xor_q <= '0;
			emit_idx_q    <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			phase_q       <= phase_d;
			byte_count_q  <= byte_count_d;
			running_xor_q <= running_xor_d;
			emit_idx_q    <= emit_idx_d;
			if (cfg_we) begin
				cfg_len_q <= cfg_wdata;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			data_byte_q <= data_byte_d;
			status_q    <= status_d;
			last_q      <= last_d;
		end
	end

	assign out_valid = out_valid_q;
	assign data_byte = data_byte_q;
	assign status    = status_q;
	assign last      = last_q;

	`XCFR_ASSERT_NOW(a_status_is_last, out_valid_q && (status_q != ST_DATA), last_q,
		"status word without last")
	`XCFR_ASSERT_NOW(a_count_below_len, phase_q == PH_DATA, byte_count_q < cfg_len_q,
		"byte count reached length while receiving payload")
	`XCFR_ASSERT_NOW(a_emit_idx_range, phase_q == PH_EMIT, CNT_W'(emit_idx_q) < cfg_len_q,
		"emit index beyond payload length")
	`XCFR_ASSERT_NEXT(a_good_sum_emits,
		step && (phase_q == PH_CHECK) && xor_match,
		(phase_q == PH_EMIT) && (emit_idx_q == '0),
		"good checksum did not start payload run")

endmodule

// ----- sv/xcfr_ram.sv -----
// Payload store: one write port, one registered read port.
module xcfr_ram #(
	parameter int DEPTH  = xcfr_pkg::MAX_PAYLOAD_DEF,
	parameter int ADDR_W = 6
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [ADDR_W-1:0]          wr_addr,
	input  logic [xcfr_pkg::BYTE_W-1:0] wr_data,
	input  logic                       rd_en,
	input  logic [ADDR_W-1:0]          rd_addr,
	output logic [xcfr_pkg::BYTE_W-1:0] rd_data
);
	import xcfr_pkg::*;

	logic [BYTE_W-1:0] mem_q [DEPTH];
	logic [BYTE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- dv/xor_checked_frame_receiver_checker.sv -----
`timescale 1ns / 100ps
// Checker for the framed byte receiver: tracks frames on the input side and checks each word out.
module xor_checked_frame_receiver_checker
	import xcfr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CNT_W-1:0]    cfg_wdata,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic [BYTE_W-1:0]   rx_byte,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [BYTE_W-1:0]   data_byte,
	input  logic [STATUS_W-1:0] status,
	input  logic                last,
	input  logic                run_done,
	output int                  fail_count,
	output int                  pending,
	output int                  words_seen,
	output int                  runs_seen,
	output int                  bad_sum_seen,
	output int                  bad_len_seen
);

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		status_t           st;
		logic              last;
	} rx_word_t;

	rx_word_t          expected_words[$];
	phase_t            rx_phase;
	logic [CNT_W-1:0]  frame_len;
	logic [CNT_W-1:0]  byte_count;
	logic [BYTE_W-1:0] running_sum;
	logic [BYTE_W-1:0] payload_mem [MAX_PAYLOAD_DEF];
	bit                leftover_done;

	task automatic report_mismatch(input string what);
		$display("checker: mismatch at %0t ns: %s", $time, what);
		fail_count++;
	endtask

	task automatic restart_hunt();
		rx_phase    = PH_HUNT;
		byte_count  = '0;
		running_sum = '0;
	endtask

	task automatic queue_word(input logic [BYTE_W-1:0] d, input status_t s, input logic l);
		rx_word_t w;
		w.data = d;
		w.st   = s;
		w.last = l;
		expected_words.push_back(w);
	endtask

	task automatic absorb_byte(input logic [BYTE_W-1:0] b);
		case (rx_phase)
			PH_HUNT: if (b == SYNC_A) rx_phase = PH_SYNC2;
			PH_SYNC2: if (b == SYNC_B) rx_phase = PH_LEN; else restart_hunt();
			PH_LEN: begin
				if (b == {1'b0, frame_len} && frame_len >= 1 && frame_len <= MAX_PAYLOAD_DEF) begin
					running_sum = b;
					byte_count  = '0;
					rx_phase    = PH_DATA;
				end else begin
					queue_word('0, ST_BAD_LEN, 1'b1);
					restart_hunt();
				end
			end
			PH_DATA: begin
				payload_mem[byte_count[5:0]] = b;
				running_sum = running_sum ^ b;
				byte_count  = byte_count + 7'd1;
				if (byte_count >= frame_len) rx_phase = PH_CHECK;
			end
			PH_CHECK: begin
				if (b == running_sum) begin
					for (int i = 0; i < frame_len; i++)
						queue_word(payload_mem[i], ST_DATA, i == frame_len - 1);
				end else begin
					queue_word('0, ST_BAD_SUM, 1'b1);
				end
				restart_hunt();
			end
			default: restart_hunt();
		endcase
	endtask

	task automatic check_word();
		rx_word_t want;
		words_seen++;
		if (expected_words.size() == 0) begin
			report_mismatch($sformatf("unexpected word data %02h status %0d last %0b",
				data_byte, status, last));
			return;
		end
		want = expected_words.pop_front();
		if (data_byte !== want.data)
			report_mismatch($sformatf("data_byte %02h, expected %02h", data_byte, want.data));
		if (status !== want.st)
			report_mismatch($sformatf("status %0d, expected %0d", status, want.st));
		if (last !== want.last)
			report_mismatch($sformatf("last %0b, expected %0b", last, want.last));
		if (want.st == ST_BAD_SUM) bad_sum_seen++;
		if (want.st == ST_BAD_LEN) bad_len_seen++;
		if (want.st == ST_DATA && want.last) runs_seen++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_words.delete();
			frame_len     = CFG_LEN_RST;
			leftover_done = 1'b0;
			restart_hunt();
		end else begin
			if (cfg_we) begin
				frame_len = cfg_wdata;
				restart_hunt();
			end
			if (out_valid && out_ready) check_word();
			if (in_valid && in_ready) absorb_byte(rx_byte);
			if (run_done && !leftover_done) begin
				leftover_done = 1'b1;
				if (expected_words.size() != 0)
					report_mismatch($sformatf("%0d words never arrived", expected_words.size()));
			end
		end
		pending = expected_words.size();
	end

endmodule

// ----- dv/tb_xor_checked_frame_receiver_top.sv -----
`timescale 1ns / 100ps
// Testbench top for the framed byte receiver: frame stimulus, length settings and the verdict.
module tb_xor_checked_frame_receiver_top;
	import xcfr_pkg::*;

	localparam int ITEM_TARGET = 270;
	localparam int CALM_AFTER  = 220;

	typedef enum int {
		FR_GOOD,
		FR_BAD_SUM,
		FR_BAD_LEN,
		FR_BAD_SYNC,
		FR_NOISE,
		FR_CUT
	} frame_kind_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [CNT_W-1:0]    cfg_wdata;
	logic                in_valid;
	logic                in_ready;
	logic [BYTE_W-1:0]   rx_byte;
	logic                out_valid;
	logic                out_ready;
	logic [BYTE_W-1:0]   data_byte;
	logic [STATUS_W-1:0] status;
	logic                last;
	logic                run_done;
	logic                calm;
	logic                gappy;
	logic [CNT_W-1:0]    cur_len;

	int fail_count, pending, words_seen, runs_seen, bad_sum_seen, bad_len_seen;
	int bytes_sent, writes_done;

	logic [BYTE_W-1:0] opening_bytes[$] = '{
		SYNC_A, SYNC_B, 8'h01, 8'h00, 8'h01,
		SYNC_A, SYNC_B, 8'h01, 8'hFF, 8'hFE,
		SYNC_A, SYNC_B, 8'h01, 8'h5A, 8'h00,
		SYNC_A, SYNC_A,
		SYNC_A, SYNC_B, 8'h02,
		SYNC_A, SYNC_B, 8'h00,
		SYNC_A, 8'h11
	};

	always #1 clk = ~clk;

	xor_checked_frame_receiver_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.data_byte (data_byte),
		.status    (status),
		.last      (last)
	);

	xor_checked_frame_receiver_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.data_byte    (data_byte),
		.status       (status),
		.last         (last),
		.run_done     (run_done),
		.fail_count   (fail_count),
		.pending      (pending),
		.words_seen   (words_seen),
		.runs_seen    (runs_seen),
		.bad_sum_seen (bad_sum_seen),
		.bad_len_seen (bad_len_seen)
	);

	task automatic put_byte(input logic [BYTE_W-1:0] b, input bit counted);
		if (gappy && !calm && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		in_valid = 1'b1;
		rx_byte  = b;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		if (counted) bytes_sent++;
	endtask

	task automatic set_length(input logic [CNT_W-1:0] v);
		in_valid = 1'b0;
		wait (pending == 0);
		repeat (8) @(negedge clk);
		cfg_wdata = v;
		cfg_we    = 1'b1;
		@(negedge clk);
		cfg_we  = 1'b0;
		cur_len = v;
		writes_done++;
	endtask

	function automatic frame_kind_t pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return FR_GOOD;
		if (r < 78) return FR_BAD_SUM;
		if (r < 88) return FR_BAD_LEN;
		if (r < 95) return FR_BAD_SYNC;
		return FR_NOISE;
	endfunction

	task automatic send_frame(input frame_kind_t kind);
		logic [BYTE_W-1:0] sum, b, len_byte;
		int n, sent;
		bit fits;
		fits  = (cur_len >= 1 && cur_len <= MAX_PAYLOAD_DEF);
		n     = fits ? int'(cur_len) : $urandom_range(0, 3);
		gappy = ($urandom_range(0, 1) == 1);
		case (kind)
			FR_NOISE: repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(0, 255)), 1'b0);
			FR_BAD_SYNC: begin
				put_byte(SYNC_A, 1'b1);
				b = ($urandom_range(0, 2) == 0) ? SYNC_A : 8'($urandom_range(0, 255));
				if (b == SYNC_B) b = 8'h00;
				put_byte(b, 1'b1);
			end
			default: begin
				put_byte(SYNC_A, 1'b1);
				put_byte(SYNC_B, 1'b1);
				len_byte = {1'b0, cur_len};
				if (kind == FR_BAD_LEN) begin
					do len_byte = 8'($urandom_range(0, 255)); while (len_byte == {1'b0, cur_len});
					n = $urandom_range(0, 2);
				end
				put_byte(len_byte, 1'b1);
				sum  = len_byte;
				sent = (kind == FR_CUT) ? $urandom_range(0, n) : n;
				for (int i = 0; i < sent; i++) begin
					b   = 8'($urandom_range(0, 255));
					sum = sum ^ b;
					put_byte(b, 1'b1);
				end
				if (kind == FR_GOOD) put_byte(sum, 1'b1);
				else if (kind == FR_BAD_SUM) put_byte(sum ^ 8'($urandom_range(1, 255)), 1'b1);
			end
		endcase
	endtask

	initial begin
		out_ready = 1'b0;
		forever begin
			if (calm) begin
				out_ready = 1'b1;
				@(negedge clk);
			end else if ($urandom_range(0, 2) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 18)) @(negedge clk);
			end else begin
				out_ready = 1'b1;
				repeat ($urandom_range(1, 40)) @(negedge clk);
			end
		end
	end

	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		logic [CNT_W-1:0] next_len;
		int phase_no, frames, wait_cycles;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_wdata   = CFG_LEN_RST;
		in_valid    = 1'b0;
		rx_byte     = '0;
		run_done    = 1'b0;
		calm        = 1'b0;
		gappy       = 1'b0;
		cur_len     = CFG_LEN_RST;
		bytes_sent  = 0;
		writes_done = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (opening_bytes[i]) put_byte(opening_bytes[i], 1'b1);

		phase_no = 0;
		while (bytes_sent < ITEM_TARGET) begin
			case (phase_no)
				0: next_len = 7'd0;
				1: next_len = 7'd127;
				2: next_len = 7'd64;
				default: next_len = 7'($urandom_range(1, 12));
			endcase
			set_length(next_len);
			frames = (next_len == 7'd64) ? 2 : $urandom_range(3, 8);
			repeat (frames) begin
				if (bytes_sent >= ITEM_TARGET) break;
				if (bytes_sent >= CALM_AFTER) calm = 1'b1;
				send_frame(pick_kind());
			end
			if (bytes_sent < ITEM_TARGET && $urandom_range(0, 3) == 0) send_frame(FR_CUT);
			phase_no++;
		end

		in_valid    = 1'b0;
		calm        = 1'b1;
		wait_cycles = 0;
		while (pending != 0 && wait_cycles < 20000) begin
			@(negedge clk);
			wait_cycles++;
		end
		repeat (12) @(negedge clk);
		run_done = 1'b1;
		repeat (2) @(negedge clk);

		$display("tb: %0d bytes sent under %0d length settings, %0d output words checked",
			bytes_sent, writes_done + 1, words_seen);
		$display("tb: %0d good payload runs, %0d checksum errors, %0d length errors",
			runs_seen, bad_sum_seen, bad_len_seen);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/xcfr_pkg.sv
sv/xcfr_ram.sv
sv/xor_checked_frame_receiver_top.sv
dv/xor_checked_frame_receiver_checker.sv
dv/tb_xor_checked_frame_receiver_top.sv
